// ===== design/bmhq_pkg.sv =====
// Shared constants, types and codes for the binary min-heap queue.
package bmhq_pkg;

    // Heap size and derived widths.
    localparam int CAPACITY = 1024;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int CHILD_W  = ADDR_W + 2;
    localparam int KEY_W    = 32;
    localparam int FILL_W   = 11;

    typedef logic signed [KEY_W-1:0] t_key;
    typedef logic [ADDR_W-1:0]       t_addr;
    typedef logic [CNT_W-1:0]        t_count;

    // Operation codes of a request.
    typedef enum logic [1:0] {
        OP_PUSH = 2'd0,
        OP_POP  = 2'd1,
        OP_PEEK = 2'd2
    } t_op;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Sequencer states.
    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_UP      = 8'b0000_0010,
        S_UP_CMP  = 8'b0000_0100,
        S_DN_LAST = 8'b0000_1000,
        S_DN_X    = 8'b0001_0000,
        S_DN      = 8'b0010_0000,
        S_DN_L    = 8'b0100_0000,
        S_DN_R    = 8'b1000_0000
    } t_state;

endpackage

// ===== design/binary_min_heap_queue.sv =====
// Top level of the binary min-heap queue: sequencer, key memory and result register.
//
// A priority queue of signed 32-bit keys kept as a binary min-heap in one
// memory of CAPACITY entries (1024). Each input request carries an opcode
// (push, pop or peek) and a key; each request gives exactly one result with
// a status, the current minimum and its valid flag, and the fill count.
// Both channels use valid and stall: a request is taken when i_valid is high
// and o_stall is low, a result when o_valid is high and i_stall is low.
// One request is worked on at a time; o_stall is high from acceptance until
// the result has been moved to the output register.
// A push sifts the new key upward; each level moved takes a memory read of
// the parent, then a compare and write. A pop reads the last key and sifts
// it downward; each level takes reads of each child present on the single
// read port, then a compare and write.
// The minimum is mirrored in a register, so peeks need no memory access.
// A result waits in the output register while the receiver stalls; the next
// request is still taken, and its result is held back until the register
// frees up. Reset empties the heap; memory contents are not cleared.
module binary_min_heap_queue
    import bmhq_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [1:0]        i_opcode,
    input  logic signed [31:0] i_key_in,
    output logic              o_stall,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [1:0]        o_status,
    output logic signed [31:0] o_min_key,
    output logic              o_min_valid,
    output logic [10:0]       o_fill_count
);

    t_state  r_state, n_state;
    t_addr   r_pos, n_pos;
    t_key    r_key, n_key;
    t_key    r_child, n_child;
    t_key    r_min, n_min;
    t_count  r_count, n_count;
    t_status r_status, n_status;
    logic    r_done, n_done;

    logic    r_out_valid;
    t_status r_out_status;
    t_key    r_out_min;
    logic    r_out_min_valid;
    t_count  r_out_count;

    logic    ram_we;
    t_addr   ram_waddr;
    t_key    ram_wdata;
    t_addr   ram_raddr;
    t_key    ram_rdata;

    logic [CHILD_W-1:0] w_n;
    logic [CHILD_W-1:0] w_left;
    logic [CHILD_W-1:0] w_right;
    t_addr   w_parent;
    logic    w_out_free;
    logic    w_take_right;
    t_key    w_best;
    t_addr   w_pick;

    // Key memory.
    bmhq_ram #(
        .WIDTH (KEY_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Tree navigation: parent of the hole and the children below it.
    assign w_n      = CHILD_W'(r_count);
    assign w_left   = {1'b0, r_pos, 1'b1};
    assign w_right  = w_left + CHILD_W'(1);
    assign w_parent = (r_pos - ADDR_W'(1)) >> 1;

    // Smaller child; the right one wins only when strictly smaller.
    assign w_take_right = ram_rdata < r_child;
    assign w_best       = w_take_right ? ram_rdata : r_child;
    assign w_pick       = w_take_right ? w_right[ADDR_W-1:0] : w_left[ADDR_W-1:0];

    assign w_out_free = !r_out_valid || !i_stall;

    // Sequencer: the sifts move a hole through the tree and write each level once.
    always_comb begin
        n_state   = r_state;
        n_pos     = r_pos;
        n_key     = r_key;
        n_child   = r_child;
        n_count   = r_count;
        n_status  = r_status;
        n_done    = r_done;
        n_min     = r_min;
        ram_we    = 1'b0;
        ram_waddr = r_pos;
        ram_wdata = r_key;
        ram_raddr = w_parent;

        unique case (r_state)
            S_IDLE: begin
                if (r_done) begin
                    // A finished request waits for the output register.
                    if (w_out_free) begin
                        n_done = 1'b0;
                    end
                end else if (i_valid) begin
                    n_status = ST_OK;
                    n_done   = 1'b1;
                    case (i_opcode)
                        OP_PUSH: begin
                            if (r_count >= CNT_W'(CAPACITY)) begin
                                n_status = ST_FULL;
                            end else begin
                                n_pos   = r_count[ADDR_W-1:0];
                                n_key   = i_key_in;
                                n_count = r_count + CNT_W'(1);
                                n_done  = 1'b0;
                                n_state = S_UP;
                            end
                        end
                        OP_POP: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_count = r_count - CNT_W'(1);
                                n_done  = 1'b0;
                                n_state = S_DN_LAST;
                            end
                        end
                        default: begin
                            // Peek and the unused code change nothing.
                        end
                    endcase
                end
            end
            S_UP: begin
                if (r_pos == '0) begin
                    ram_we  = 1'b1;
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                ram_we = 1'b1;
                if (r_key < ram_rdata) begin
                    ram_wdata = ram_rdata;
                    n_pos     = w_parent;
                    n_state   = S_UP;
                end else begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_DN_LAST: begin
                ram_raddr = r_count[ADDR_W-1:0];
                n_state   = S_DN_X;
            end
            S_DN_X: begin
                n_key   = ram_rdata;
                n_pos   = '0;
                n_state = S_DN;
            end
            S_DN: begin
                if (w_left >= w_n) begin
                    ram_we  = 1'b1;
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    ram_raddr = w_left[ADDR_W-1:0];
                    n_state   = S_DN_L;
                end
            end
            S_DN_L: begin
                n_child = ram_rdata;
                if (w_right < w_n) begin
                    ram_raddr = w_right[ADDR_W-1:0];
                    n_state   = S_DN_R;
                end else begin
                    ram_we = 1'b1;
                    if (ram_rdata < r_key) begin
                        ram_wdata = ram_rdata;
                        n_pos     = w_left[ADDR_W-1:0];
                        n_state   = S_DN;
                    end else begin
                        n_done  = 1'b1;
                        n_state = S_IDLE;
                    end
                end
            end
            S_DN_R: begin
                ram_we = 1'b1;
                if (w_best < r_key) begin
                    ram_wdata = w_best;
                    n_pos     = w_pick;
                    n_state   = S_DN;
                end else begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Keep a copy of the root so the minimum is always at hand.
        if (ram_we && ram_waddr == '0) begin
            n_min = ram_wdata;
        end
    end

    // Sequencer registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= n_done;
        end
        r_pos    <= n_pos;
        r_key    <= n_key;
        r_child  <= n_child;
        r_min    <= n_min;
        r_status <= n_status;
    end

    // Output register: loaded from a finished request when it is free.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_IDLE && r_done && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
        if (r_state == S_IDLE && r_done && w_out_free) begin
            r_out_status    <= r_status;
            r_out_min       <= (r_count != '0) ? r_min : '0;
            r_out_min_valid <= (r_count != '0);
            r_out_count     <= r_count;
        end
    end

    assign o_stall      = (r_state != S_IDLE) || r_done;
    assign o_valid      = r_out_valid;
    assign o_status     = r_out_status;
    assign o_min_key    = r_out_min;
    assign o_min_valid  = r_out_min_valid;
    assign o_fill_count = FILL_W'(r_out_count);

endmodule

// ===== design/bmhq_ram.sv =====
// Generic single-write, single-read memory with registered read data.
module bmhq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/bmhq_chk.sv =====
// Port-level checks on the results of the binary min-heap queue, with their bind.
module bmhq_chk
    import bmhq_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_valid,
    input logic              i_stall,
    input logic [1:0]        o_status,
    input logic signed [31:0] o_min_key,
    input logic              o_min_valid,
    input logic [10:0]       o_fill_count
);

    // The valid flag agrees with the fill count.
    a_min_valid_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_min_valid == (o_fill_count != '0)))
        else $error("min_valid disagrees with fill_count");

    // An empty heap reports a zero minimum.
    a_empty_key_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_min_valid) |-> (o_min_key == '0))
        else $error("empty heap reports a nonzero minimum");

    // A rejected pop can only happen on an empty heap.
    a_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_EMPTY) |-> (o_fill_count == '0 && !o_min_valid))
        else $error("empty status with keys held");

    // A rejected push can only happen on a full heap.
    a_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_FULL) |-> (o_fill_count == FILL_W'(CAPACITY)))
        else $error("full status with room left");

    // A stalled result holds its status, minimum key and fill count.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_status) && $stable(o_min_key)
                                  && $stable(o_fill_count)))
        else $error("stalled result changed");

endmodule

bind binary_min_heap_queue bmhq_chk u_bmhq_chk (.*);
